>>> rtl/stw_pkg.sv
// Shared types and constants for the strided tile address walker.
// No dependencies; every rtl file imports this package.
`timescale 1ns / 1ps

package stw_pkg;

	localparam int DIM_BITS   = 16;
	localparam int IDX_BITS   = 32;
	localparam int CFG_BITS   = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int DIV_STEPS  = 32;
	localparam int DIV_CNT_W  = 5;
	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 64;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEPTH_STRIDE   = 3'd0,
		REG_BATCH_STRIDE   = 3'd1,
		REG_CHANNEL_STRIDE = 3'd2,
		REG_DEPTH_COUNT    = 3'd3,
		REG_BATCH_COUNT    = 3'd4,
		REG_CHANNEL_COUNT  = 3'd5,
		REG_ROW_TILES      = 3'd6,
		REG_COL_TILES      = 3'd7
	} reg_idx_t;

	typedef enum logic {
		KIND_START = 1'b0,
		KIND_STEP  = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		PH_DEPTH   = 2'd0,
		PH_BATCH   = 2'd1,
		PH_CHANNEL = 2'd2,
		PH_ROW     = 2'd3
	} div_phase_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PC,
		ST_PB,
		ST_PD,
		ST_CHK,
		ST_DIV,
		ST_DIVX,
		ST_B0,
		ST_B1,
		ST_B2,
		ST_B3,
		ST_B4,
		ST_SM0,
		ST_SM1,
		ST_SM2,
		ST_ADV
	} state_t;

	typedef struct packed {
		logic start;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

>>> rtl/stw_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on stw_pkg.
`timescale 1ns / 1ps

module stw_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  stw_pkg::div_ctl_t            ctl,
	input  logic [stw_pkg::IDX_BITS-1:0] dividend,
	input  logic [2*stw_pkg::IDX_BITS-1:0] divisor,
	output logic [stw_pkg::IDX_BITS-1:0] quotient,
	output logic [stw_pkg::IDX_BITS-1:0] remainder,
	output stw_pkg::div_sts_t            sts
);
	import stw_pkg::*;

	logic [IDX_BITS-1:0]   quo_q;
	logic [IDX_BITS-1:0]   rem_q;
	logic [2*IDX_BITS-1:0] den_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [IDX_BITS:0]     trial;
	logic                  fits;
	logic                  last_step;

	assign trial     = {rem_q, quo_q[IDX_BITS-1]};
	assign fits      = {{(IDX_BITS-1){1'b0}}, trial} >= den_q;
	assign last_step = busy_q && !ctl.start && (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= last_step;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last_step) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			// subtract when the trial remainder covers the divisor
			rem_q <= fits ? IDX_BITS'(trial - den_q[IDX_BITS:0]) : trial[IDX_BITS-1:0];
			quo_q <= {quo_q[IDX_BITS-2:0], fits};
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
	assign sts.busy  = busy_q;
	assign sts.done  = done_q;

endmodule

>>> rtl/strided_tile_address_walker.sv
// Top level of the strided tile address walker: sequencer, shared multiplier,
// counters and output register. Depends on stw_pkg and stw_div.
//
// channel  | dir | beat contents
// s_*      | in  | tuser: kind; tdata: start_tile, tile_count, shard_width
// m_*      | out | tdata: src_tile, dst_tile; tlast: last_tile
// cfg_*    | in  | write enable, register index, write data
//
// A start beat runs three products of the tile sizes on the shared 48x16
// multiplier, four 32-step divisions on the divider, then the multiply-accumulate
// states ST_B0 to ST_B4 for the source row base, unless the job proves empty.
// A step beat with an active job runs the accept cycle, the multiplier states
// ST_SM0 to ST_SM2 for the wrap deltas, then ST_ADV, which loads the output register.
// s_tready is high only while the sequencer is idle. The advance cycle holds
// while the previous result still waits in the output register.
// Reset is asynchronous and leaves the block idle with no job.
`timescale 1ns / 1ps

module strided_tile_address_walker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [31:0] start_tile, [63:32] tile_count, [79:64] shard_width
	input  logic [stw_pkg::IN_DATA_W-1:0]   s_tdata,
	// [0] kind
	input  logic [0:0]                      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [31:0] src_tile, [63:32] dst_tile
	output logic [stw_pkg::OUT_DATA_W-1:0]  m_tdata,
	output logic                            m_tlast,
	input  logic                            cfg_we,
	input  logic [stw_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [stw_pkg::CFG_BITS-1:0]    cfg_data
);
	import stw_pkg::*;

	// configuration
	logic [IDX_BITS-1:0] ds_q, bs_q, cs_q;
	logic [DIM_BITS-1:0] dc_q, bc_q, cc_q, rt_q, ct_q;

	// sequencer
	state_t     state_q, state_d;
	div_phase_t phase_q;

	// job state
	logic                job_active_q;
	logic [DIM_BITS-1:0] depth_q, batch_q, chan_q, row_q;
	logic [DIM_BITS:0]   col_q, row_end_q;
	logic [DIM_BITS-1:0] row_start_q, shard_q;
	logic [IDX_BITS-1:0] base_q, dst_base_q, done_q, wanted_q;
	logic [IDX_BITS-1:0] delta_r_q, delta_c_q;
	logic [IDX_BITS-1:0] per_chan_q;
	logic [47:0]         per_batch_q;

	// shared multiplier
	logic [47:0] mul_a;
	logic [15:0] mul_b;
	logic        mul_en;
	logic [63:0] prod_q;

	// divider
	div_ctl_t              div_ctl;
	div_sts_t              div_sts;
	logic [IDX_BITS-1:0]   div_num, div_quo, div_rem;
	logic [2*IDX_BITS-1:0] div_den;

	logic in_acc, out_free;
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !m_tvalid || m_tready;

	stw_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (div_ctl),
		.dividend  (div_num),
		.divisor   (div_den),
		.quotient  (div_quo),
		.remainder (div_rem),
		.sts       (div_sts)
	);

	// advance terms
	logic [DIM_BITS:0]   col_inc, row_inc, chan_inc, batch_inc, depth_inc;
	logic                row_wrap, r_wrap, c_wrap, b_wrap, d_end;
	logic [IDX_BITS-1:0] delta_b, base_next, dst_next, done_inc;
	logic                active_next;
	logic                empty_job;

	assign col_inc   = col_q + 1'b1;
	assign row_inc   = {1'b0, row_q} + 1'b1;
	assign chan_inc  = {1'b0, chan_q} + 1'b1;
	assign batch_inc = {1'b0, batch_q} + 1'b1;
	assign depth_inc = {1'b0, depth_q} + 1'b1;
	assign row_wrap  = col_inc >= row_end_q;
	assign r_wrap    = row_wrap && (row_inc >= {1'b0, rt_q});
	assign c_wrap    = r_wrap && (chan_inc >= {1'b0, cc_q});
	assign b_wrap    = c_wrap && (batch_inc >= {1'b0, bc_q});
	assign d_end     = b_wrap && (depth_inc >= {1'b0, dc_q});
	assign delta_b   = ds_q - prod_q[IDX_BITS-1:0];
	assign base_next = base_q
		+ (row_wrap ? {{(IDX_BITS-DIM_BITS){1'b0}}, ct_q} : '0)
		+ (r_wrap ? delta_r_q : '0)
		+ (c_wrap ? delta_c_q : '0)
		+ (b_wrap ? delta_b : '0);
	assign dst_next  = (row_wrap && shard_q != '0)
		? dst_base_q + {{(IDX_BITS-DIM_BITS){1'b0}}, ct_q}
			- {{(IDX_BITS-DIM_BITS){1'b0}}, shard_q}
		: dst_base_q;
	assign done_inc    = done_q + 1'b1;
	assign active_next = !d_end && !(done_inc >= wanted_q);
	assign empty_job   = (wanted_q == '0) || (prod_q == '0) || (dc_q == '0);

	// next state, multiplier operands, divider launch
	always_comb begin
		state_d   = state_q;
		mul_a     = '0;
		mul_b     = '0;
		mul_en    = 1'b0;
		div_ctl   = '0;
		div_num   = div_rem;
		div_den   = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (kind_t'(s_tuser[0]) == KIND_START) state_d = ST_PC;
					else if (job_active_q) state_d = ST_SM0;
				end
			end
			ST_PC: begin
				mul_a = {32'b0, ct_q}; mul_b = rt_q; mul_en = 1'b1;
				state_d = ST_PB;
			end
			ST_PB: begin
				mul_a = prod_q[47:0]; mul_b = cc_q; mul_en = 1'b1;
				state_d = ST_PD;
			end
			ST_PD: begin
				mul_a = prod_q[47:0]; mul_b = bc_q; mul_en = 1'b1;
				state_d = ST_CHK;
			end
			ST_CHK: begin
				if (empty_job) state_d = ST_IDLE;
				else begin
					div_ctl.start = 1'b1;
					div_num = dst_base_q;
					div_den = prod_q;
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_sts.done) state_d = ST_DIVX;
			end
			ST_DIVX: begin
				case (phase_q)
					PH_DEPTH: begin
						if (div_quo >= {16'b0, dc_q}) state_d = ST_IDLE;
						else begin
							div_ctl.start = 1'b1;
							div_den = {16'b0, per_batch_q};
							state_d = ST_DIV;
						end
					end
					PH_BATCH: begin
						div_ctl.start = 1'b1;
						div_den = {32'b0, per_chan_q};
						state_d = ST_DIV;
					end
					PH_CHANNEL: begin
						div_ctl.start = 1'b1;
						div_den = {48'b0, ct_q};
						state_d = ST_DIV;
					end
					default: state_d = ST_B0;
				endcase
			end
			ST_B0: begin
				mul_a = {16'b0, ds_q}; mul_b = depth_q; mul_en = 1'b1;
				state_d = ST_B1;
			end
			ST_B1: begin
				mul_a = {16'b0, bs_q}; mul_b = batch_q; mul_en = 1'b1;
				state_d = ST_B2;
			end
			ST_B2: begin
				mul_a = {16'b0, cs_q}; mul_b = chan_q; mul_en = 1'b1;
				state_d = ST_B3;
			end
			ST_B3: begin
				mul_a = {32'b0, ct_q}; mul_b = row_q; mul_en = 1'b1;
				state_d = ST_B4;
			end
			ST_B4: state_d = ST_IDLE;
			ST_SM0: begin
				mul_a = {32'b0, ct_q}; mul_b = rt_q; mul_en = 1'b1;
				state_d = ST_SM1;
			end
			ST_SM1: begin
				mul_a = {16'b0, cs_q}; mul_b = cc_q; mul_en = 1'b1;
				state_d = ST_SM2;
			end
			ST_SM2: begin
				mul_a = {16'b0, bs_q}; mul_b = bc_q; mul_en = 1'b1;
				state_d = ST_ADV;
			end
			ST_ADV: begin
				// hold until the output register is free
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (mul_en) prod_q <= mul_a * mul_b;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ds_q <= '0; bs_q <= '0; cs_q <= '0;
			dc_q <= 16'd1; bc_q <= 16'd1; cc_q <= 16'd1; rt_q <= 16'd1; ct_q <= 16'd1;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_DEPTH_STRIDE:   ds_q <= cfg_data;
				REG_BATCH_STRIDE:   bs_q <= cfg_data;
				REG_CHANNEL_STRIDE: cs_q <= cfg_data;
				REG_DEPTH_COUNT:    dc_q <= cfg_data[DIM_BITS-1:0];
				REG_BATCH_COUNT:    bc_q <= cfg_data[DIM_BITS-1:0];
				REG_CHANNEL_COUNT:  cc_q <= cfg_data[DIM_BITS-1:0];
				REG_ROW_TILES:      rt_q <= cfg_data[DIM_BITS-1:0];
				REG_COL_TILES:      ct_q <= cfg_data[DIM_BITS-1:0];
				default: ;
			endcase
		end
	end

	// control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_active_q <= 1'b0;
			m_tvalid     <= 1'b0;
			phase_q      <= PH_DEPTH;
		end else begin
			// load a new beat in the advance cycle, otherwise drop it once taken
			if (state_q == ST_ADV && out_free) m_tvalid <= 1'b1;
			else if (m_tready) m_tvalid <= 1'b0;
			if (state_q == ST_IDLE && in_acc && kind_t'(s_tuser[0]) == KIND_START) begin
				job_active_q <= 1'b0;
				phase_q      <= PH_DEPTH;
			end
			if (state_q == ST_DIVX) phase_q <= div_phase_t'(phase_q + 2'd1);
			if (state_q == ST_B4) job_active_q <= 1'b1;
			if (state_q == ST_ADV && out_free) job_active_q <= active_next;
		end
	end

	// job datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && kind_t'(s_tuser[0]) == KIND_START) begin
					dst_base_q <= s_tdata[31:0];
					wanted_q   <= s_tdata[63:32];
					shard_q    <= s_tdata[79:64];
					done_q     <= '0;
				end
			end
			ST_PB: per_chan_q  <= prod_q[IDX_BITS-1:0];
			ST_PD: per_batch_q <= prod_q[47:0];
			ST_DIVX: begin
				case (phase_q)
					PH_DEPTH:   depth_q <= div_quo[DIM_BITS-1:0];
					PH_BATCH:   batch_q <= div_quo[DIM_BITS-1:0];
					PH_CHANNEL: chan_q  <= div_quo[DIM_BITS-1:0];
					default: begin
						row_q       <= div_quo[DIM_BITS-1:0];
						row_start_q <= div_rem[DIM_BITS-1:0];
						col_q       <= {1'b0, div_rem[DIM_BITS-1:0]};
						row_end_q   <= (shard_q != '0)
							? {1'b0, div_rem[DIM_BITS-1:0]} + {1'b0, shard_q}
							: {1'b0, ct_q};
					end
				endcase
			end
			ST_B1: base_q <= prod_q[IDX_BITS-1:0];
			ST_B2, ST_B3, ST_B4: base_q <= base_q + prod_q[IDX_BITS-1:0];
			ST_SM1: delta_r_q <= cs_q - prod_q[IDX_BITS-1:0];
			ST_SM2: delta_c_q <= bs_q - prod_q[IDX_BITS-1:0];
			ST_ADV: begin
				if (out_free) begin
					// emit from the current position, then advance the counters
					m_tdata    <= {dst_base_q + done_q,
						base_q + {{(IDX_BITS-DIM_BITS-1){1'b0}}, col_q}};
					m_tlast    <= !active_next;
					done_q     <= done_inc;
					base_q     <= base_next;
					dst_base_q <= dst_next;
					if (row_wrap) begin
						col_q <= (shard_q != '0) ? {1'b0, row_start_q} : '0;
						if (shard_q == '0) row_start_q <= '0;
						row_q <= r_wrap ? '0 : row_inc[DIM_BITS-1:0];
					end else begin
						col_q <= col_inc;
					end
					if (r_wrap) chan_q <= c_wrap ? '0 : chan_inc[DIM_BITS-1:0];
					if (c_wrap) batch_q <= b_wrap ? '0 : batch_inc[DIM_BITS-1:0];
					if (b_wrap) depth_q <= depth_inc[DIM_BITS-1:0];
				end
			end
			default: ;
		endcase
	end

endmodule

>>> rtl/stw_checker.sv
// Port-level checks for the strided tile address walker, bound to the top.
// Depends on stw_pkg and strided_tile_address_walker.
`timescale 1ns / 1ps

module stw_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [0:0]                     s_tuser,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [stw_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic                           m_tlast
);
	import stw_pkg::*;

	logic start_beat;
	assign start_beat = s_tvalid && s_tready && (s_tuser[0] == KIND_START);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start_beat |=> !s_tready)
		else $error("ready right after start beat");

	a_start_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		start_beat |=> !$rose(m_tvalid))
		else $error("result right after start beat");

	a_rise_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result without step work");

endmodule

bind strided_tile_address_walker stw_checker u_stw_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

>>> bench/tb_top.sv
// Self-checking bench for strided_tile_address_walker: directed and random jobs
// checked against an in-bench model of the walker. Depends on stw_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
	import stw_pkg::*;

	localparam int QUIET_LIMIT = 5000; // idle cycles before the watchdog fires
	localparam int DRAIN_WAIT  = 300;  // longer than a start beat plus a step beat

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	// [31:0] start_tile, [63:32] tile_count, [79:64] shard_width
	logic [IN_DATA_W-1:0]  s_tdata;
	// [0] kind
	logic [0:0]            s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	// [31:0] src_tile, [63:32] dst_tile
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_BITS-1:0]   cfg_data;

	strided_tile_address_walker dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// One expected tile pair.
	typedef struct packed {
		logic [31:0] src;
		logic [31:0] dst;
		logic        last;
	} tile_pair_t;

	tile_pair_t pending_pairs[$];

	int errors;
	int beats_sent;
	int pairs_seen;
	int jobs_started;
	bit send_calm;  // when set, the sender never idles
	bit recv_calm;  // when set, the receiver never stalls

	// Register shadow of the walker.
	logic [31:0] depth_stride_r, batch_stride_r, channel_stride_r;
	logic [15:0] depth_count_r, batch_count_r, channel_count_r, rows_r, cols_r;

	// Walker state shadow.
	logic        walking;
	logic [15:0] d_at, b_at, c_at, r_at;
	logic [16:0] col_at, row_end;
	logic [15:0] row_first, shard_lat;
	logic [31:0] src_base, dst_base, done_n, wanted_n;

	typedef logic [31:0] reg_set_t [8];

	function automatic void reset_walker();
		depth_stride_r = '0; batch_stride_r = '0; channel_stride_r = '0;
		depth_count_r = 16'd1; batch_count_r = 16'd1; channel_count_r = 16'd1;
		rows_r = 16'd1; cols_r = 16'd1;
		walking = 1'b0;
		d_at = '0; b_at = '0; c_at = '0; r_at = '0;
		col_at = '0; row_end = '0; row_first = '0; shard_lat = '0;
		src_base = '0; dst_base = '0; done_n = '0; wanted_n = '0;
	endfunction

	function automatic void shadow_reg(reg_idx_t idx, logic [31:0] v);
		case (idx)
			REG_DEPTH_STRIDE: depth_stride_r = v;
			REG_BATCH_STRIDE: batch_stride_r = v;
			REG_CHANNEL_STRIDE: channel_stride_r = v;
			REG_DEPTH_COUNT: depth_count_r = v[15:0];
			REG_BATCH_COUNT: batch_count_r = v[15:0];
			REG_CHANNEL_COUNT: channel_count_r = v[15:0];
			REG_ROW_TILES: rows_r = v[15:0];
			default: cols_r = v[15:0];
		endcase
	endfunction

	// Split the start tile into coordinates and latch the row window.
	function automatic void open_job(logic [31:0] st, logic [31:0] cnt, logic [15:0] shard);
		logic [63:0] per_chan, per_batch, per_depth, rem, t, tw, dq;
		per_chan  = 64'(rows_r) * 64'(cols_r);
		per_batch = per_chan * 64'(channel_count_r);
		per_depth = per_batch * 64'(batch_count_r);
		walking  = 1'b0;
		done_n   = '0;
		wanted_n = cnt;
		if (cnt == 0 || per_depth == 0 || depth_count_r == 0)
			return;
		dq = 64'(st) / per_depth;
		if (dq >= 64'(depth_count_r))
			return;
		d_at = dq[15:0];
		rem  = 64'(st) % per_depth;
		b_at = 16'(rem / per_batch);
		rem  = rem % per_batch;
		c_at = 16'(rem / per_chan);
		t    = rem % per_chan;
		r_at = 16'(t / 64'(cols_r));
		tw   = t % 64'(cols_r);
		shard_lat = shard;
		row_first = tw[15:0];
		col_at    = 17'(tw);
		row_end   = (shard != 0) ? 17'(tw) + 17'(shard) : 17'(cols_r);
		src_base  = 32'(d_at) * depth_stride_r + 32'(b_at) * batch_stride_r
			+ 32'(c_at) * channel_stride_r + 32'(r_at) * 32'(cols_r);
		dst_base  = st;
		walking   = 1'b1;
	endfunction

	// Emit the current pair, then advance column, row, channel, batch, depth.
	function automatic void walk_step();
		tile_pair_t p;
		if (!walking)
			return;
		p.src = src_base + 32'(col_at);
		p.dst = dst_base + done_n;
		done_n = done_n + 1;
		col_at = col_at + 1;
		if (col_at >= row_end) begin
			src_base = src_base + 32'(cols_r);
			if (shard_lat != 0)
				dst_base = dst_base + 32'(cols_r) - 32'(shard_lat);
			else
				row_first = '0;
			col_at = 17'(row_first);
			r_at = r_at + 1;
			if (r_at >= rows_r) begin
				r_at = '0;
				src_base = src_base + channel_stride_r - 32'(rows_r) * 32'(cols_r);
				c_at = c_at + 1;
				if (c_at >= channel_count_r) begin
					c_at = '0;
					src_base = src_base + batch_stride_r - channel_stride_r * 32'(channel_count_r);
					b_at = b_at + 1;
					if (b_at >= batch_count_r) begin
						b_at = '0;
						src_base = src_base + depth_stride_r - batch_stride_r * 32'(batch_count_r);
						d_at = d_at + 1;
						if (d_at >= depth_count_r)
							walking = 1'b0;
					end
				end
			end
		end
		if (done_n >= wanted_n)
			walking = 1'b0;
		p.last = !walking;
		pending_pairs.push_back(p);
	endfunction

	function automatic int draw_gap(bit calm);
		if (calm || $urandom_range(0, 2) != 0)
			return 0;
		return $urandom_range(0, 16);
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// Send one beat; the model advances at the edge that accepts it.
	task automatic send_beat(kind_t k, logic [31:0] st, logic [31:0] cnt, logic [15:0] shard);
		int gap;
		gap = draw_gap(send_calm);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= k;
		s_tdata  <= {shard, cnt, st};
		do @(posedge clk); while (!s_tready);
		beats_sent++;
		if (k == KIND_START) begin
			jobs_started++;
			open_job(st, cnt, shard);
		end else begin
			walk_step();
		end
	endtask

	task automatic step_beats(int n);
		repeat (n) send_beat(KIND_STEP, $urandom, $urandom, 16'($urandom));
	endtask

	// Drop valid, wait for every expected pair, then let the sequencer go idle.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_pairs.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// Write every register in index order; only call while settled.
	task automatic load_regs(reg_set_t v);
		for (int i = 0; i < 8; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data  <= v[i];
			@(posedge clk);
			shadow_reg(reg_idx_t'(i), v[i]);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Result side: check each beat, then stall for a drawn number of cycles.
	int hold_left;
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready  <= 1'b0;
			hold_left <= 0;
		end else begin
			int h;
			h = hold_left;
			if (m_tvalid && m_tready) begin
				pairs_seen++;
				if (pending_pairs.size() == 0) begin
					report("unexpected beat src", m_tdata[31:0], 32'h0);
				end else begin
					tile_pair_t e;
					e = pending_pairs.pop_front();
					if (m_tdata[31:0] != e.src)
						report("src_tile", m_tdata[31:0], e.src);
					if (m_tdata[63:32] != e.dst)
						report("dst_tile", m_tdata[63:32], e.dst);
					if (m_tlast != e.last)
						report("last_tile", 32'(m_tlast), 32'(e.last));
				end
				h = draw_gap(recv_calm);
			end
			if (h > 0) begin
				m_tready  <= 1'b0;
				hold_left <= h - 1;
			end else begin
				m_tready  <= 1'b1;
				hold_left <= 0;
			end
		end
	end

	// Watchdog: count cycles with no beat and no register write.
	int quiet;
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !arst_n)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Reset values, a single job, idle steps.
	task automatic test_reset_values();
		step_beats(2);                        // idle steps: no job yet
		send_beat(KIND_START, 32'd0, 32'd1, 16'd0);
		step_beats(3);                        // one pair, then idle again
		settle();
	endtask

	// Small tensor: wraps into the next row and the next channel, sharding, abandon, empty jobs.
	task automatic test_directed_shapes();
		reg_set_t v;
		v = '{32'd1000, 32'd100000, 32'd7, 32'd2, 32'd3, 32'd2, 32'd3, 32'd4};
		load_regs(v);
		send_beat(KIND_START, 32'd5, 32'hFFFF_FFFF, 16'd0); // huge count, left unfinished
		step_beats(8);
		send_beat(KIND_START, 32'd2, 32'd9, 16'd2);         // abandon the first job
		step_beats(10);
		send_beat(KIND_START, 32'd144, 32'd4, 16'd0);       // beyond depth: empty
		step_beats(1);
		send_beat(KIND_START, 32'd3, 32'd0, 16'd0);         // zero count: empty
		step_beats(1);
		send_beat(KIND_START, 32'hFFFF_FFFF, 32'd3, 16'hFFFF);
		step_beats(1);
		settle();
	endtask

	// Extreme registers, then a zero count register.
	task automatic test_extreme_regs();
		reg_set_t v;
		v = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'd65535, 32'd65535, 32'd65535, 32'd65535, 32'd65535};
		load_regs(v);
		send_beat(KIND_START, 32'hFFFF_FFFF, 32'd4, 16'hFFFF);
		step_beats(5);
		send_beat(KIND_START, 32'd65534, 32'd3, 16'd0);
		step_beats(3);
		settle();
		v = '{32'd0, 32'd0, 32'd0, 32'd1, 32'd0, 32'd1, 32'd1, 32'd1};
		load_regs(v);
		send_beat(KIND_START, 32'd0, 32'd2, 16'd0);         // zero batch count: empty
		step_beats(2);
		settle();
	endtask

	// Random phases: a fresh register set each, then mostly well-formed jobs.
	task automatic test_random_jobs();
		reg_set_t v;
		logic [63:0] span;
		logic [31:0] st, cnt;
		logic [15:0] shard;
		for (int ph = 0; ph < 10; ph++) begin
			send_calm = (ph % 4 == 1);
			recv_calm = (ph % 4 == 2);
			v[0] = $urandom; v[1] = $urandom; v[2] = $urandom;
			if (ph == 9) begin
				for (int i = 3; i < 8; i++) v[i] = $urandom_range(1, 65535);
			end else begin
				for (int i = 3; i < 8; i++) v[i] = $urandom_range(1, 4);
				v[7] = $urandom_range(1, 6);
			end
			load_regs(v);
			span = 64'(rows_r) * cols_r * channel_count_r * batch_count_r * depth_count_r;
			while (beats_sent < 30 + (ph + 1) * 105) begin
				if ($urandom_range(0, 7) == 0) begin
					st = $urandom; cnt = $urandom; shard = 16'($urandom);
				end else begin
					st = (span > 64'hFFFF_FFFF) ? $urandom : 32'($urandom % span);
					cnt = $urandom_range(1, 40);
					shard = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom_range(1, cols_r));
				end
				send_beat(KIND_START, st, cnt, shard);
				step_beats(int'(cnt > 40 ? 40 : cnt) + $urandom_range(0, 4) - 2);
			end
			settle();
		end
		send_calm = 1'b0;
		recv_calm = 1'b0;
	endtask

	initial begin
		errors = 0; beats_sent = 0; pairs_seen = 0; jobs_started = 0;
		send_calm = 1'b0; recv_calm = 1'b0;
		reset_walker();
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_directed_shapes();
		test_extreme_regs();
		test_random_jobs();

		$display("covered %0d input beats, %0d jobs, %0d tile pairs checked",
			beats_sent, jobs_started, pairs_seen);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
